FILE: hw/rtl/tun_pkg.sv
package tun_pkg;

  // width of each unit-normal component on the result channel
  localparam int NORMAL_BITS = 16;

  // register stages in the vertex-to-squared-length front end
  localparam int FRONT_STAGES = 5;

endpackage

FILE: hw/rtl/tun_front.sv
module tun_front #(
  parameter int CB  = 14,
  parameter int SQW = 2 * (2 * CB + 2),
  parameter int LW  = SQW + 2
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic signed [CB-1:0]  v0x,
  input  logic signed [CB-1:0]  v0y,
  input  logic signed [CB-1:0]  v0z,
  input  logic signed [CB-1:0]  v1x,
  input  logic signed [CB-1:0]  v1y,
  input  logic signed [CB-1:0]  v1z,
  input  logic signed [CB-1:0]  v2x,
  input  logic signed [CB-1:0]  v2y,
  input  logic signed [CB-1:0]  v2z,
  output logic [SQW-1:0]        sq_x,
  output logic [SQW-1:0]        sq_y,
  output logic [SQW-1:0]        sq_z,
  output logic [LW-1:0]         len2,
  output logic [2:0]            neg,
  output logic                  degen
);

  localparam int EW = CB + 1;
  localparam int PW = 2 * EW;
  localparam int CW = PW + 1;
  localparam int MW = CW - 1;

  // edges: 0..2 = v1 - v0, 3..5 = v2 - v0
  logic signed [EW-1:0] e_r [6];
  logic signed [PW-1:0] p_r [6];
  logic [MW-1:0]        mag_r [3];
  logic [2:0]           neg2_r, neg3_r, neg4_r;
  logic [SQW-1:0]       sq3_r [3];
  logic [SQW-1:0]       sq4_r [3];
  logic [LW-1:0]        len2_r;
  logic                 degen_r;

  logic signed [CW-1:0] c_nxt [3];

  always_comb begin
    c_nxt[0] = CW'(p_r[0]) - CW'(p_r[1]);
    c_nxt[1] = CW'(p_r[2]) - CW'(p_r[3]);
    c_nxt[2] = CW'(p_r[4]) - CW'(p_r[5]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_r[0] <= EW'(v1x) - EW'(v0x);
      e_r[1] <= EW'(v1y) - EW'(v0y);
      e_r[2] <= EW'(v1z) - EW'(v0z);
      e_r[3] <= EW'(v2x) - EW'(v0x);
      e_r[4] <= EW'(v2y) - EW'(v0y);
      e_r[5] <= EW'(v2z) - EW'(v0z);

      // c = e2 x e1
      p_r[0] <= PW'(e_r[4]) * PW'(e_r[2]);
      p_r[1] <= PW'(e_r[5]) * PW'(e_r[1]);
      p_r[2] <= PW'(e_r[5]) * PW'(e_r[0]);
      p_r[3] <= PW'(e_r[3]) * PW'(e_r[2]);
      p_r[4] <= PW'(e_r[3]) * PW'(e_r[1]);
      p_r[5] <= PW'(e_r[4]) * PW'(e_r[0]);

      for (int i = 0; i < 3; i++) begin
        mag_r[i]  <= c_nxt[i][CW-1] ? MW'(-c_nxt[i]) : MW'(c_nxt[i]);
        neg2_r[i] <= c_nxt[i][CW-1];
        sq3_r[i]  <= SQW'(mag_r[i]) * SQW'(mag_r[i]);
        sq4_r[i]  <= sq3_r[i];
      end
      neg3_r <= neg2_r;
      neg4_r <= neg3_r;

      len2_r  <= LW'(sq3_r[0]) + LW'(sq3_r[1]) + LW'(sq3_r[2]);
      degen_r <= (sq3_r[0] == '0) && (sq3_r[1] == '0) && (sq3_r[2] == '0);
    end
  end

  assign sq_x  = sq4_r[0];
  assign sq_y  = sq4_r[1];
  assign sq_z  = sq4_r[2];
  assign len2  = len2_r;
  assign neg   = neg4_r;
  assign degen = degen_r;

endmodule

FILE: hw/rtl/tun_div.sv
module tun_div #(
  parameter int SQW = 30,
  parameter int LW  = 32,
  parameter int D   = 31
) (
  input  logic           clk,
  input  logic           en,
  input  logic [SQW-1:0] num,
  input  logic [LW-1:0]  den,
  output logic [D-1:0]   quo
);

  // restoring divide, one quotient bit per stage; num <= den on entry
  logic [LW:0]   r_r [D];
  logic [D-1:0]  q_r [D];
  logic [LW-1:0] l_r [D];

  for (genvar k = 0; k < D; k++) begin : g_stage
    logic [LW:0]   r_in, r_sub;
    logic [D-1:0]  q_in;
    logic [LW-1:0] l_in;
    logic          ge;

    if (k == 0) begin : g_first
      assign r_in = (LW + 1)'(num);
      assign q_in = '0;
      assign l_in = den;
    end else begin : g_next
      assign r_in = r_r[k-1];
      assign q_in = q_r[k-1];
      assign l_in = l_r[k-1];
    end

    assign ge    = r_in >= {1'b0, l_in};
    assign r_sub = ge ? r_in - {1'b0, l_in} : r_in;

    always_ff @(posedge clk) begin
      if (en) begin
        r_r[k] <= {r_sub[LW-1:0], 1'b0};
        q_r[k] <= {q_in[D-2:0], ge};
        l_r[k] <= l_in;
      end
    end
  end

  assign quo = q_r[D-1];

endmodule

FILE: hw/rtl/tun_sqrt.sv
module tun_sqrt #(
  parameter int S = 16
) (
  input  logic             clk,
  input  logic             en,
  input  logic [2*S-2:0]   rad,
  output logic [S-1:0]     root
);

  localparam int RW = S + 1;

  // digit-by-digit integer square root, one root bit per stage
  logic [2*S-1:0] rad_r  [S];
  logic [RW-1:0]  rem_r  [S];
  logic [S-1:0]   root_r [S];

  for (genvar k = 0; k < S; k++) begin : g_stage
    logic [2*S-1:0] rad_in;
    logic [RW-1:0]  rem_in;
    logic [S-1:0]   root_in;
    logic [RW+1:0]  remx, trial, rem_new;
    logic           ge;

    if (k == 0) begin : g_first
      assign rad_in  = {1'b0, rad};
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign rad_in  = rad_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
    end

    assign remx    = {rem_in, rad_in[2*S-1:2*S-2]};
    assign trial   = {1'b0, root_in, 2'b01};
    assign ge      = remx >= trial;
    assign rem_new = ge ? remx - trial : remx;

    always_ff @(posedge clk) begin
      if (en) begin
        rad_r[k]  <= {rad_in[2*S-3:0], 2'b00};
        rem_r[k]  <= rem_new[RW-1:0];
        root_r[k] <= {root_in[S-2:0], ge};
      end
    end
  end

  assign root = root_r[S-1];

endmodule

FILE: hw/rtl/triangle_unit_normal.sv
// Unit face normal of a triangle. Each beat on the input carries three vertices
// as signed integers; the block forms the edges e1 = v1 - v0, e2 = v2 - v0, the
// cross product c = e2 x e1 and its squared length L, and returns each component
// as round(c_i * 2^F / sqrt(L)) in signed Q1.F (ties away from zero), F being
// NORMAL_FRAC_BITS. A triangle with L = 0 gives a zero normal with degenerate
// set. Throughput is one triangle per cycle while in_ready is high. The path to
// the output register runs through five front-end stages (edges, products,
// cross, squares, sum), a restoring divider producing one bit of
// c_i^2 * 2^(2F+2) / L per stage, and a digit-serial square root giving one
// root bit per stage; the round-to-nearest falls out of the extra root bit.
// The pipeline moves as one; an output register plus a skid register let the
// block keep taking beats while a finished result waits, and in_ready drops
// only once the skid register is holding a result.
module triangle_unit_normal #(
  parameter int COORD_BITS       = 14,
  parameter int NORMAL_FRAC_BITS = 14
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_BITS-1:0]  in_vertex0_x,
  input  logic signed [COORD_BITS-1:0]  in_vertex0_y,
  input  logic signed [COORD_BITS-1:0]  in_vertex0_z,
  input  logic signed [COORD_BITS-1:0]  in_vertex1_x,
  input  logic signed [COORD_BITS-1:0]  in_vertex1_y,
  input  logic signed [COORD_BITS-1:0]  in_vertex1_z,
  input  logic signed [COORD_BITS-1:0]  in_vertex2_x,
  input  logic signed [COORD_BITS-1:0]  in_vertex2_y,
  input  logic signed [COORD_BITS-1:0]  in_vertex2_z,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [tun_pkg::NORMAL_BITS-1:0] out_normal_x,
  output logic signed [tun_pkg::NORMAL_BITS-1:0] out_normal_y,
  output logic signed [tun_pkg::NORMAL_BITS-1:0] out_normal_z,
  output logic                          out_degenerate
);

  localparam int NB  = tun_pkg::NORMAL_BITS;
  localparam int FS  = tun_pkg::FRONT_STAGES;
  localparam int MW  = 2 * COORD_BITS + 2;          // |c_i|
  localparam int SQW = 2 * MW;                      // c_i^2
  localparam int LW  = SQW + 2;                     // L
  localparam int D   = 2 * NORMAL_FRAC_BITS + 3;    // quotient bits
  localparam int S   = NORMAL_FRAC_BITS + 2;        // root bits
  localparam int DS  = D + S;
  localparam int NST = FS + DS;

  typedef struct packed {
    logic [2:0] neg;
    logic       degen;
  } side_t;

  typedef struct packed {
    logic [NB-1:0] nx;
    logic [NB-1:0] ny;
    logic [NB-1:0] nz;
    logic          degen;
  } res_t;

  // whole pipeline advances together; held only while the skid is occupied
  logic en;
  logic sk_v_r, out_v_r;
  res_t sk_r, out_r, res;

  assign en       = !sk_v_r;
  assign in_ready = en;

  logic [NST-1:0] v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[NST-2:0], in_valid};
    end
  end

  // front end: edges through squared length
  logic [SQW-1:0] sq [3];
  logic [LW-1:0]  len2;
  side_t          side_f;

  tun_front #(.CB(COORD_BITS), .SQW(SQW), .LW(LW)) u_front (
    .clk   (clk),
    .en    (en),
    .v0x   (in_vertex0_x),
    .v0y   (in_vertex0_y),
    .v0z   (in_vertex0_z),
    .v1x   (in_vertex1_x),
    .v1y   (in_vertex1_y),
    .v1z   (in_vertex1_z),
    .v2x   (in_vertex2_x),
    .v2y   (in_vertex2_y),
    .v2z   (in_vertex2_z),
    .sq_x  (sq[0]),
    .sq_y  (sq[1]),
    .sq_z  (sq[2]),
    .len2  (len2),
    .neg   (side_f.neg),
    .degen (side_f.degen)
  );

  // signs and the degenerate flag ride alongside the divide and root
  side_t side_r [DS];

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= side_f;
      for (int k = 1; k < DS; k++) begin
        side_r[k] <= side_r[k-1];
      end
    end
  end

  // per component: R = floor(c^2 * 2^(2F+2) / L), m = isqrt(R), q = (m+1)/2
  logic [S-1:0]  root [3];
  logic [NB-1:0] comp [3];

  for (genvar i = 0; i < 3; i++) begin : g_lane
    logic [D-1:0]  quo;
    logic [S:0]    m_inc;
    logic [31:0]   q_ext;

    tun_div #(.SQW(SQW), .LW(LW), .D(D)) u_div (
      .clk (clk),
      .en  (en),
      .num (sq[i]),
      .den (len2),
      .quo (quo)
    );

    tun_sqrt #(.S(S)) u_sqrt (
      .clk  (clk),
      .en   (en),
      .rad  (quo),
      .root (root[i])
    );

    assign m_inc = (S + 1)'(root[i]) + (S + 1)'(1);
    assign q_ext = 32'(m_inc[S:1]);

    always_comb begin
      if (side_r[DS-1].degen) begin
        comp[i] = '0;
      end else if (side_r[DS-1].neg[i]) begin
        comp[i] = NB'(-q_ext);
      end else begin
        comp[i] = NB'(q_ext);
      end
    end
  end

  assign res = '{nx: comp[0], ny: comp[1], nz: comp[2], degen: side_r[DS-1].degen};

  // output register with one skid entry behind it
  logic res_v;
  assign res_v = en && v_r[NST-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
      sk_v_r  <= 1'b0;
    end else if (out_v_r && !out_ready) begin
      if (res_v) begin
        sk_v_r <= 1'b1;
        sk_r   <= res;
      end
    end else if (sk_v_r) begin
      out_v_r <= 1'b1;
      out_r   <= sk_r;
      sk_v_r  <= 1'b0;
    end else begin
      out_v_r <= res_v;
      out_r   <= res;
    end
  end

  assign out_valid      = out_v_r;
  assign out_normal_x   = out_r.nx;
  assign out_normal_y   = out_r.ny;
  assign out_normal_z   = out_r.nz;
  assign out_degenerate = out_r.degen;

endmodule

FILE: hw/rtl/tun_checker.sv
module tun_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [tun_pkg::NORMAL_BITS-1:0] out_normal_x,
  input logic [tun_pkg::NORMAL_BITS-1:0] out_normal_y,
  input logic [tun_pkg::NORMAL_BITS-1:0] out_normal_z,
  input logic                            out_degenerate
);

  // stalled result beat holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_normal_x)
      && $stable(out_normal_y) && $stable(out_normal_z) && $stable(out_degenerate))
    else $error("result beat changed while stalled");

  // degenerate triangles give a zero normal
  a_degen: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_degenerate |-> out_normal_x == '0 && out_normal_y == '0
      && out_normal_z == '0)
    else $error("degenerate beat with non-zero normal");

  // nothing emerges straight out of reset
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind triangle_unit_normal tun_checker u_tun_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_normal_x   (out_normal_x),
  .out_normal_y   (out_normal_y),
  .out_normal_z   (out_normal_z),
  .out_degenerate (out_degenerate)
);
